// ----- rtl/core/hhs_pkg.sv -----
// hhs_pkg: shared types and constants for the heater hysteresis switch
// no dependencies; used by hhs_cfg_regs, hhs_decide and the top level

package hhs_pkg;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_MIN_ON_MS  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_OFF_MS = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_ON_MS  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_LOW   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_HIGH  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MIN_POWER  = 3'd5;

    localparam int unsigned CfgDataW = 32;

    // status codes
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_BLK_OFF = 2'd1;
    localparam logic [1:0] ST_BLK_ON  = 2'd2;

    // request payload
    typedef struct packed {
        logic        [31:0] now_ms;
        logic        [15:0] offered_power;
        logic signed [15:0] temperature;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic        granted;
        logic        relay_on;
        logic [15:0] allowed_power;
        logic [1:0]  status;
        logic [31:0] on_duration_ms;
        logic [31:0] off_duration_ms;
    } t_out_item;

    // configuration registers
    typedef struct packed {
        logic        [31:0] min_on_ms;
        logic        [31:0] min_off_ms;
        logic        [31:0] max_on_ms;
        logic signed [15:0] temp_low;
        logic signed [15:0] temp_high;
        logic        [15:0] min_power;
    } t_cfg;

    // relay state carried from request to request
    typedef struct packed {
        logic        relay;
        logic [31:0] on_stamp;
        logic        on_vld;
        logic [31:0] off_stamp;
        logic        off_vld;
        logic        first_req;
        logic [1:0]  status;
        logic [31:0] last_on_len;
        logic [31:0] last_off_len;
    } t_state;

endpackage

// ----- rtl/core/hhs_cfg_regs.sv -----
// hhs_cfg_regs: configuration register file written through a plain write port
// depends on hhs_pkg

module hhs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hhs_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [hhs_pkg::CfgDataW-1:0]  i_cfg_wdata,
    output hhs_pkg::t_cfg                 o_cfg
);

    hhs_pkg::t_cfg r_cfg;
    hhs_pkg::t_cfg n_cfg;

    // decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                hhs_pkg::CFG_MIN_ON_MS:  n_cfg.min_on_ms  = i_cfg_wdata;
                hhs_pkg::CFG_MIN_OFF_MS: n_cfg.min_off_ms = i_cfg_wdata;
                hhs_pkg::CFG_MAX_ON_MS:  n_cfg.max_on_ms  = i_cfg_wdata;
                hhs_pkg::CFG_TEMP_LOW:   n_cfg.temp_low   = $signed(i_cfg_wdata[15:0]);
                hhs_pkg::CFG_TEMP_HIGH:  n_cfg.temp_high  = $signed(i_cfg_wdata[15:0]);
                hhs_pkg::CFG_MIN_POWER:  n_cfg.min_power  = i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/hhs_decide.sv -----
// hhs_decide: one-pass relay decision, next state and grant for one request
// depends on hhs_pkg

module hhs_decide (
    input  hhs_pkg::t_cfg     i_cfg,
    input  hhs_pkg::t_state   i_state,
    input  hhs_pkg::t_in_item i_item,
    output hhs_pkg::t_state   o_state,
    output logic              o_granted
);

    logic [32:0] w_max_lim;
    logic [32:0] w_on_lim;
    logic [32:0] w_off_lim;
    logic        w_max_hit;
    logic        w_pow_low;
    logic        w_too_warm;
    logic        w_too_cold;
    logic        w_do_off;
    logic        w_do_on;
    logic        w_off_ok;
    logic        w_on_ok;

    // deadline sums kept one bit wider so they never wrap
    assign w_max_lim = {1'b0, i_state.on_stamp} + {1'b0, i_cfg.max_on_ms};
    assign w_on_lim  = {1'b0, i_state.on_stamp} + {1'b0, i_cfg.min_on_ms};
    assign w_off_lim = {1'b0, i_state.off_stamp} + {1'b0, i_cfg.min_off_ms};

    // case conditions in priority order
    assign w_max_hit  = i_state.on_vld && (i_cfg.max_on_ms != '0) && i_state.relay
                        && ({1'b0, i_item.now_ms} > w_max_lim);
    assign w_pow_low  = i_item.offered_power < i_cfg.min_power;
    assign w_too_warm = $signed(i_item.temperature) >= $signed(i_cfg.temp_high);
    assign w_too_cold = $signed(i_item.temperature) < $signed(i_cfg.temp_low);

    assign w_do_off = w_max_hit || w_pow_low || w_too_warm;
    assign w_do_on  = !w_do_off && (w_too_cold || i_state.first_req);

    // minimum time checks
    assign w_off_ok = !i_state.on_vld || ({1'b0, i_item.now_ms} >= w_on_lim);
    assign w_on_ok  = !i_state.off_vld || ({1'b0, i_item.now_ms} >= w_off_lim);

    // next state and grant
    always_comb begin
        o_state   = i_state;
        o_granted = 1'b0;
        if (w_do_off) begin
            if (w_off_ok) begin
                if (i_state.relay) begin
                    o_state.last_on_len = i_item.now_ms - i_state.on_stamp;
                    o_state.off_stamp   = i_item.now_ms;
                    o_state.off_vld     = 1'b1;
                    o_state.relay       = 1'b0;
                end
                o_state.status = hhs_pkg::ST_READY;
            end else begin
                o_state.status = hhs_pkg::ST_BLK_ON;
            end
            // only the low power case reports its outcome
            o_granted = !w_max_hit && w_pow_low && w_off_ok;
        end else if (w_do_on) begin
            if (!w_too_cold) begin
                o_state.first_req = 1'b0;
            end
            if (w_on_ok) begin
                if (!i_state.relay) begin
                    if (i_state.off_vld) begin
                        o_state.last_off_len = i_item.now_ms - i_state.off_stamp;
                    end
                    o_state.on_stamp = i_item.now_ms;
                    o_state.on_vld   = 1'b1;
                    o_state.relay    = 1'b1;
                end
                o_state.status = hhs_pkg::ST_READY;
            end else begin
                o_state.status = hhs_pkg::ST_BLK_OFF;
            end
            o_granted = w_on_ok;
        end
    end

endmodule

// ----- rtl/core/heater_hysteresis_switch_core.sv -----
// heater_hysteresis_switch_core: thermostat relay with hysteresis, min/max on-off times
// depends on hhs_pkg, hhs_cfg_regs, hhs_decide
//
//   channel   direction  handshake                payload
//   request   in         i_in_valid / o_in_ready  i_in_data  (hhs_pkg::t_in_item)
//   result    out        o_out_valid / i_out_ready o_out_data (hhs_pkg::t_out_item)
//   config    in         i_cfg_we (no wait)       i_cfg_idx, i_cfg_wdata
//
// one request per cycle sustained while results are taken; a result is presented once its request
// has passed the input register, then the decision and result register
// the relay state updates in the same cycle the result register loads
// synchronous active-low reset clears state and config; no clearing pass
// a stalled result holds one request in the input register, then o_in_ready drops

module heater_hysteresis_switch_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hhs_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hhs_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [hhs_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [hhs_pkg::CfgDataW-1:0]  i_cfg_wdata
);

    // relay state after reset: off, never switched, first request pending
    localparam hhs_pkg::t_state StateRst = '{
        relay:        1'b0,
        on_stamp:     32'd0,
        on_vld:       1'b0,
        off_stamp:    32'd0,
        off_vld:      1'b0,
        first_req:    1'b1,
        status:       hhs_pkg::ST_READY,
        last_on_len:  32'd0,
        last_off_len: 32'd0
    };

    hhs_pkg::t_cfg      w_cfg;
    hhs_pkg::t_state    r_state;
    hhs_pkg::t_state    n_state;
    hhs_pkg::t_in_item  r_in;
    hhs_pkg::t_out_item r_out;
    logic               r_in_vld;
    logic               r_out_vld;
    logic               w_granted;
    logic               w_out_free;
    logic               w_advance;

    // configuration registers
    hhs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // decision logic
    hhs_decide u_decide (
        .i_cfg     (w_cfg),
        .i_state   (r_state),
        .i_item    (r_in),
        .o_state   (n_state),
        .o_granted (w_granted)
    );

    // pipeline flow control
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_advance  = r_in_vld && w_out_free;
    assign o_in_ready = !r_in_vld || w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // relay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateRst;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
        if (w_advance) begin
            r_out <= '{
                granted:         w_granted,
                relay_on:        n_state.relay,
                allowed_power:   n_state.relay ? w_cfg.min_power : 16'd0,
                status:          n_state.status,
                on_duration_ms:  n_state.last_on_len,
                off_duration_ms: n_state.last_off_len
            };
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // relay on always has a switch-on time behind it
    a_relay_has_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.relay |-> r_state.on_vld)
        else $error("relay on without switch-on stamp");

    // a switch-off can only follow a switch-on
    a_off_after_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.off_vld |-> r_state.on_vld)
        else $error("switch-off stamp without switch-on stamp");

    // an empty result register never stalls the request side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with empty result register");

    // no power taken while the relay is off
    a_power_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.relay_on) |-> (o_out_data.allowed_power == 16'd0))
        else $error("power reported with relay off");
`endif

endmodule

// ----- bench/tb_heater_hysteresis_switch_core.sv -----
// tb_heater_hysteresis_switch_core: self-checking bench for the heater hysteresis switch
// depends on hhs_pkg and heater_hysteresis_switch_core; directed and random requests,
// an in-bench relay predictor, random idling on both channels
`timescale 1ns / 100ps

module tb_heater_hysteresis_switch_core;

    localparam int RandSettings   = 12;
    localparam int ReqsPerSetting = 137;

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    hhs_pkg::t_in_item                   i_in_data   = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    hhs_pkg::t_out_item                  o_out_data;
    logic                                i_cfg_we    = 1'b0;
    logic [hhs_pkg::CfgIdxW-1:0]         i_cfg_idx   = '0;
    logic [hhs_pkg::CfgDataW-1:0]        i_cfg_wdata = '0;

    // requests waiting to be driven, predicted results waiting to arrive
    hhs_pkg::t_in_item  pend_reqs[$];
    hhs_pkg::t_out_item expected_results[$];

    // predictor copy of relay state and registers
    hhs_pkg::t_state    relay_st;
    hhs_pkg::t_cfg      cfg_shadow;

    logic      req_taken = 1'b0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    logic [31:0] wall_ms = '0;
    hhs_pkg::t_out_item want;

    int mismatch_count = 0;
    int req_count = 0;
    int result_count = 0;
    int setting_count = 0;
    int switch_on_count = 0;
    int blocked_count = 0;

    heater_hysteresis_switch_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // switch-on attempt, blocked inside the minimum off time
    function automatic bit attempt_on(input logic [31:0] now_ms);
        if (!relay_st.off_vld ||
            {1'b0, now_ms} >= {1'b0, relay_st.off_stamp} + {1'b0, cfg_shadow.min_off_ms}) begin
            if (!relay_st.relay) begin
                if (relay_st.off_vld) begin
                    relay_st.last_off_len = now_ms - relay_st.off_stamp;
                end
                relay_st.on_stamp = now_ms;
                relay_st.on_vld   = 1'b1;
                relay_st.relay    = 1'b1;
                switch_on_count++;
            end
            relay_st.status = hhs_pkg::ST_READY;
            return 1'b1;
        end
        relay_st.status = hhs_pkg::ST_BLK_OFF;
        blocked_count++;
        return 1'b0;
    endfunction

    // switch-off attempt, blocked inside the minimum on time
    function automatic bit attempt_off(input logic [31:0] now_ms);
        if (!relay_st.on_vld ||
            {1'b0, now_ms} >= {1'b0, relay_st.on_stamp} + {1'b0, cfg_shadow.min_on_ms}) begin
            if (relay_st.relay) begin
                relay_st.last_on_len = now_ms - relay_st.on_stamp;
                relay_st.off_stamp   = now_ms;
                relay_st.off_vld     = 1'b1;
                relay_st.relay       = 1'b0;
            end
            relay_st.status = hhs_pkg::ST_READY;
            return 1'b1;
        end
        relay_st.status = hhs_pkg::ST_BLK_ON;
        blocked_count++;
        return 1'b0;
    endfunction

    // relay decision for one request, in priority order
    function automatic hhs_pkg::t_out_item predict_relay(input hhs_pkg::t_in_item req);
        hhs_pkg::t_out_item r;
        bit                 grant;
        grant = 1'b0;
        if (relay_st.on_vld && cfg_shadow.max_on_ms != 32'd0 && relay_st.relay &&
            {1'b0, req.now_ms} > {1'b0, relay_st.on_stamp} + {1'b0, cfg_shadow.max_on_ms}) begin
            void'(attempt_off(req.now_ms));
        end else if (req.offered_power < cfg_shadow.min_power) begin
            grant = attempt_off(req.now_ms);
        end else if ($signed(req.temperature) >= $signed(cfg_shadow.temp_high)) begin
            void'(attempt_off(req.now_ms));
        end else if ($signed(req.temperature) < $signed(cfg_shadow.temp_low)) begin
            grant = attempt_on(req.now_ms);
        end else if (relay_st.first_req) begin
            relay_st.first_req = 1'b0;
            grant = attempt_on(req.now_ms);
        end
        r.granted         = grant;
        r.relay_on        = relay_st.relay;
        r.allowed_power   = relay_st.relay ? cfg_shadow.min_power : 16'd0;
        r.status          = relay_st.status;
        r.on_duration_ms  = relay_st.last_on_len;
        r.off_duration_ms = relay_st.last_off_len;
        return r;
    endfunction

    // random request, temperatures and power clustered around the current limits
    function automatic hhs_pkg::t_in_item make_random_req();
        hhs_pkg::t_in_item r;
        int       sel;
        int       lo_t;
        int       hi_t;
        int       t;
        int       p;
        int       mp;
        lo_t = int'($signed(cfg_shadow.temp_low));
        hi_t = int'($signed(cfg_shadow.temp_high));
        mp   = int'(cfg_shadow.min_power);

        sel = $urandom_range(0, 99);
        if (sel < 3 && wall_ms > 32'd500) begin
            wall_ms  = wall_ms - $urandom_range(0, 500);
            r.now_ms = wall_ms;
        end else if (sel == 3) begin
            r.now_ms = $urandom_range(0, wall_ms);
        end else if (sel < 15) begin
            r.now_ms = wall_ms;
        end else begin
            wall_ms  = wall_ms + $urandom_range(1, 150);
            r.now_ms = wall_ms;
        end

        case ($urandom_range(0, 9))
            0: t = int'($urandom_range(0, 65535)) - 32768;
            1: t = lo_t - 1;
            2: t = lo_t;
            3: t = hi_t - 1;
            4: t = hi_t;
            5, 6: t = lo_t - int'($urandom_range(1, 200));
            7, 8: t = (hi_t > lo_t) ? lo_t + int'($urandom_range(0, hi_t - lo_t - 1)) : lo_t;
            default: t = hi_t + int'($urandom_range(0, 200));
        endcase
        if (t < -32768) t = -32768;
        if (t > 32767) t = 32767;
        r.temperature = t[15:0];

        case ($urandom_range(0, 9))
            0, 1: p = $urandom_range(0, 65535);
            2: p = (mp > 0) ? $urandom_range(0, mp - 1) : 0;
            3: p = mp;
            default: p = mp + $urandom_range(0, 65535 - mp);
        endcase
        r.offered_power = p[15:0];
        return r;
    endfunction

    // random register setting, now and then wide timers, crossed or extreme limits
    function automatic hhs_pkg::t_cfg make_random_cfg();
        hhs_pkg::t_cfg c;
        int   lo;
        int   span;
        c.min_on_ms  = $urandom_range(0, 600);
        c.min_off_ms = $urandom_range(0, 600);
        c.max_on_ms  = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(300, 4000);
        lo   = int'($urandom_range(0, 600)) - 300;
        span = $urandom_range(0, 400);
        c.temp_low  = lo[15:0];
        c.temp_high = 16'(lo + span);
        c.min_power = 16'($urandom_range(0, 3000));
        case ($urandom_range(0, 9))
            0: begin
                c.min_on_ms  = $urandom();
                c.min_off_ms = $urandom();
                c.max_on_ms  = $urandom();
            end
            1: begin
                c.temp_low  = 16'(lo + span + 1);
                c.temp_high = lo[15:0];
            end
            2: begin
                c.temp_low  = 16'h8000;
                c.temp_high = 16'h7fff;
                c.min_power = 16'($urandom_range(60000, 65535));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [hhs_pkg::CfgIdxW-1:0] idx,
                             input logic [hhs_pkg::CfgDataW-1:0] word);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= word;
    endtask

    // write all six registers; upper bits of the 16-bit ones carry junk
    task automatic apply_config(input hhs_pkg::t_cfg c);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(hhs_pkg::CFG_MIN_ON_MS, c.min_on_ms);
        write_reg(hhs_pkg::CFG_MIN_OFF_MS, c.min_off_ms);
        write_reg(hhs_pkg::CFG_MAX_ON_MS, c.max_on_ms);
        write_reg(hhs_pkg::CFG_TEMP_LOW, {junk[31:16], c.temp_low});
        write_reg(hhs_pkg::CFG_TEMP_HIGH, {junk[15:0], c.temp_high});
        write_reg(hhs_pkg::CFG_MIN_POWER, {junk[23:8], c.min_power});
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_shadow = c;
        setting_count++;
    endtask

    task automatic push_req(input logic [31:0] now_ms, input int power, input int temp);
        hhs_pkg::t_in_item r;
        r.now_ms        = now_ms;
        r.offered_power = power[15:0];
        r.temperature   = temp[15:0];
        pend_reqs.push_back(r);
    endtask

    // block idle: every request driven and every result back
    task automatic wait_drained();
        while (pend_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    // request driver: new request only once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (pend_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_in_data  <= pend_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_relay(i_in_data));
                req_count++;
            end
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request pending, expected none, actual %0h",
                             $time, o_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("granted", 32'(want.granted), 32'(o_out_data.granted));
                    check_field("relay_on", 32'(want.relay_on), 32'(o_out_data.relay_on));
                    check_field("allowed_power", 32'(want.allowed_power),
                                32'(o_out_data.allowed_power));
                    check_field("status", 32'(want.status), 32'(o_out_data.status));
                    check_field("on_duration_ms", want.on_duration_ms,
                                o_out_data.on_duration_ms);
                    check_field("off_duration_ms", want.off_duration_ms,
                                o_out_data.off_duration_ms);
                end
            end
        end
    end

    // stimulus
    initial begin
        hhs_pkg::t_cfg c;
        relay_st           = '0;
        relay_st.first_req = 1'b1;
        relay_st.status    = hhs_pkg::ST_READY;
        cfg_shadow         = '0;
        tx_idle_pct  = 8;
        rx_stall_pct = 80;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: cold switches on, warm switches off
        push_req(32'd0, 0, -32768);
        push_req(32'd5, 65535, 32767);
        wait_drained();

        // moderate timers: first request blocked by min off, min on, power low, max on
        c = '0;
        c.min_on_ms  = 32'd100;
        c.min_off_ms = 32'd50;
        c.max_on_ms  = 32'd1000;
        c.temp_low   = 16'sd100;
        c.temp_high  = 16'sd300;
        c.min_power  = 16'd500;
        apply_config(c);
        push_req(32'd10, 1000, 200);
        push_req(32'd60, 1000, 200);
        push_req(32'd60, 1000, 50);
        push_req(32'd100, 1000, 400);
        push_req(32'd120, 100, 200);
        push_req(32'd160, 499, 200);
        push_req(32'd210, 1000, 99);
        push_req(32'd1210, 1000, 99);
        push_req(32'd1211, 1000, 99);
        push_req(32'd1211, 1000, 99);
        push_req(32'd100, 1000, 99);
        wait_drained();

        // widest timers: sums past 32 bits must still block
        c.min_on_ms  = 32'hffff_ffff;
        c.min_off_ms = 32'hffff_ffff;
        c.max_on_ms  = 32'd0;
        c.temp_low   = 16'sh8000;
        c.temp_high  = 16'sh7fff;
        c.min_power  = 16'hffff;
        apply_config(c);
        push_req(32'hffff_ffff, 65535, -32768);
        push_req(32'hffff_ffff, 65534, 0);
        push_req(32'd0, 65535, 32767);
        wait_drained();

        // crossed limits, then shortest max on time
        c.temp_low   = 16'sh7fff;
        c.temp_high  = 16'sh8000;
        c.min_power  = 16'd0;
        apply_config(c);
        push_req(32'd1250, 0, 0);
        wait_drained();
        c.min_on_ms  = 32'd0;
        c.min_off_ms = 32'd0;
        c.max_on_ms  = 32'd1;
        c.temp_low   = 16'sd0;
        c.temp_high  = 16'sd10;
        apply_config(c);
        push_req(32'd1300, 0, -1);
        push_req(32'd1301, 0, 5);
        push_req(32'd1302, 0, 5);
        push_req(32'd1302, 0, -1);
        push_req(32'd1303, 0, -1);
        wait_drained();

        // random settings across the three idling phases, time jumping ahead each time
        wall_ms = 32'd1400;
        for (int s = 0; s < RandSettings; s++) begin
            if (s == RandSettings / 3) begin
                tx_idle_pct  = 80;
                rx_stall_pct = 8;
            end else if (s == 2 * RandSettings / 3) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            wait_drained();
            apply_config(make_random_cfg());
            wall_ms = wall_ms + $urandom_range(32'h1000_0000, 32'h1400_0000);
            for (int n = 0; n < ReqsPerSetting; n++) begin
                pend_reqs.push_back(make_random_req());
            end
        end
        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("checked %0d results for %0d requests over %0d register settings",
                 result_count, req_count, setting_count);
        $display("relay switched on %0d times, %0d attempts blocked by min on/off time",
                 switch_on_count, blocked_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hhs_pkg.sv
rtl/core/hhs_cfg_regs.sv
rtl/core/hhs_decide.sv
rtl/core/heater_hysteresis_switch_core.sv
bench/tb_heater_hysteresis_switch_core.sv
